/* design/text_screen_char_writer_defines.svh */
// assertion macros shared by the screen writer rtl
`ifndef TEXT_SCREEN_CHAR_WRITER_DEFINES_SVH
`define TEXT_SCREEN_CHAR_WRITER_DEFINES_SVH

`ifndef SYNTH
// checked property, quiet while reset is asserted
`define TSCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also watched during reset
`define TSCW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSCW_ASSERT(lbl, prop, msg)
`define TSCW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/tscw_pkg.sv */
package tscw_pkg;

    // default geometry of the cell store
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;

    // field widths
    localparam int CHAR_W     = 8;
    localparam int RD_ROW_W   = 6;
    localparam int RD_COL_W   = 7;
    localparam int CELL_W     = 9;
    localparam int OUT_ROW_W  = 6;
    localparam int OUT_COL_W  = 8;
    localparam int COLS_CFG_W = 8;
    localparam int ROWS_CFG_W = 7;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'd1;

    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd24;

    // codes
    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam logic [CHAR_W-1:0] NEWLINE_BYTE = 8'd10;
    localparam logic [CHAR_W-1:0] NULL_BYTE    = 8'd0;
    localparam logic [CELL_W-1:0] BLANK_CELL   = 9'h1FF;

endpackage

/* design/tscw_ram.sv */
module tscw_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/text_screen_char_writer.sv */
// channel  | handshake          | payload
// ---------+--------------------+------------------------------------------------
// in       | in_valid/in_ready  | func, char_in, read_row, read_col
// out      | out_valid/out_ready| cell_value, cursor_row_out, cursor_col_out, scrolled
// cfg      | cfg_we             | cfg_index, cfg_data
//
// a read runs S_DECIDE, S_RD_DATA, S_DONE; a put runs S_DECIDE, S_WRITE, S_DONE
// a newline without scroll, a zero byte or a read outside the store go S_DECIDE to S_DONE
// a scroll runs S_SCROLL, one cell moved per cycle, S_FLUSH, S_BLANK; a single row: S_BLANK
// after reset S_CLEAR_ALL sweeps the store to blank, in_ready stays low
// one beat is worked on at a time; a finished result sits in the output register
// while the next beat is taken, a full output register only holds the last step

`include "text_screen_char_writer_defines.svh"

module text_screen_char_writer #(
    parameter int MAX_COLS = tscw_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tscw_pkg::DEF_MAX_ROWS
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [tscw_pkg::CHAR_W-1:0]         char_in,
    input  logic [tscw_pkg::RD_ROW_W-1:0]       read_row,
    input  logic [tscw_pkg::RD_COL_W-1:0]       read_col,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tscw_pkg::CELL_W-1:0]  cell_value,
    output logic [tscw_pkg::OUT_ROW_W-1:0]      cursor_row_out,
    output logic [tscw_pkg::OUT_COL_W-1:0]      cursor_col_out,
    output logic                                scrolled,

    input  logic                                cfg_we,
    input  logic [tscw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tscw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROWS_W = $clog2(MAX_ROWS + 1);
    localparam int COLS_W = $clog2(MAX_COLS + 1);
    localparam int CELL_W = tscw_pkg::CELL_W;

    typedef enum logic [8:0] {
        S_CLEAR_ALL = 9'b000000001,
        S_IDLE      = 9'b000000010,
        S_DECIDE    = 9'b000000100,
        S_RD_DATA   = 9'b000001000,
        S_SCROLL    = 9'b000010000,
        S_FLUSH     = 9'b000100000,
        S_BLANK     = 9'b001000000,
        S_WRITE     = 9'b010000000,
        S_DONE      = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COLS_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]  sr_reg, sr_next;
    logic [COL_W-1:0]  sc_reg, sc_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              scrolled_reg, scrolled_next;
    logic [tscw_pkg::COLS_CFG_W-1:0] cols_reg;
    logic [tscw_pkg::ROWS_CFG_W-1:0] rows_reg;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic                          func_reg;
    logic [tscw_pkg::CHAR_W-1:0]   ch_reg;
    logic [tscw_pkg::RD_ROW_W-1:0] rr_reg;
    logic [tscw_pkg::RD_COL_W-1:0] rc_reg;
    logic [CELL_W-1:0]             cell_reg, cell_next;
    logic [CELL_W-1:0]             out_cell_reg;
    logic [tscw_pkg::OUT_ROW_W-1:0] out_row_reg;
    logic [tscw_pkg::OUT_COL_W-1:0] out_col_reg;
    logic                          out_scr_reg;

    logic              in_fire;
    logic              out_load;
    logic [COLS_W-1:0] cols_eff;
    logic [ROWS_W-1:0] rows_eff;
    logic [ROW_W-1:0]  rows_m1;
    logic [COLS_W-1:0] cols_m1;
    logic [ROWS_W:0]   row_p1;
    logic              is_newline;
    logic              need_down;
    logic              can_step;
    logic              rd_in_range;
    logic              sc_last;

    // shared address unit
    logic [ROW_W-1:0]  a_row;
    logic [COL_W-1:0]  a_col;
    logic [ADDR_W-1:0] addr;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] ram_rdata;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // register values clamped into the store
    always_comb
    begin
        if (cols_reg == '0)
            cols_eff = COLS_W'(1);
        else if (32'(cols_reg) > MAX_COLS)
            cols_eff = COLS_W'(MAX_COLS);
        else
            cols_eff = COLS_W'(cols_reg);

        if (rows_reg == '0)
            rows_eff = ROWS_W'(1);
        else if (32'(rows_reg) > MAX_ROWS)
            rows_eff = ROWS_W'(MAX_ROWS);
        else
            rows_eff = ROWS_W'(rows_reg);
    end

    assign rows_m1     = ROW_W'(rows_eff - ROWS_W'(1));
    assign cols_m1     = cols_eff - COLS_W'(1);
    assign row_p1      = (ROWS_W+1)'(row_reg) + (ROWS_W+1)'(1);
    assign can_step    = row_p1 < (ROWS_W+1)'(rows_eff);
    assign is_newline  = (ch_reg == tscw_pkg::NEWLINE_BYTE);
    assign need_down   = is_newline || (col_reg >= cols_eff);
    assign rd_in_range = (32'(rr_reg) < MAX_ROWS) && (32'(rc_reg) < MAX_COLS);
    assign sc_last     = (COLS_W'(sc_reg) == cols_m1);

    always_comb
    begin
        unique case (state_reg)
            S_DECIDE:
            begin
                a_row = ROW_W'(rr_reg);
                a_col = COL_W'(rc_reg);
            end
            S_SCROLL:
            begin
                a_row = sr_reg;
                a_col = sc_reg;
            end
            S_BLANK:
            begin
                a_row = rows_m1;
                a_col = sc_reg;
            end
            default:
            begin
                a_row = row_reg;
                a_col = COL_W'(col_reg);
            end
        endcase
    end

    assign addr = ADDR_W'(ADDR_W'(a_row) * ADDR_W'(MAX_COLS)) + ADDR_W'(a_col);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr;
        ram_wdata = tscw_pkg::BLANK_CELL;
        priority if (state_reg == S_CLEAR_ALL)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
        end
        else if (pend_valid_reg)
        begin
            // cell read last cycle goes one row up
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = ram_rdata;
        end
        else if (state_reg == S_BLANK)
        begin
            ram_we = 1'b1;
        end
        else if (state_reg == S_WRITE)
        begin
            ram_we    = 1'b1;
            ram_wdata = {1'b0, ch_reg};
        end
    end

    tscw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        sr_next         = sr_reg;
        sc_next         = sc_reg;
        scrolled_next   = scrolled_reg;
        cell_next       = cell_reg;
        pend_valid_next = (state_reg == S_SCROLL);
        pend_addr_next  = addr - ADDR_W'(MAX_COLS);
        out_load        = 1'b0;

        unique case (state_reg)
            S_CLEAR_ALL:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                scrolled_next = 1'b0;
                cell_next     = '0;
                if (func_reg == tscw_pkg::FUNC_READ)
                begin
                    if (rd_in_range)
                        state_next = S_RD_DATA;
                    else
                    begin
                        cell_next  = tscw_pkg::BLANK_CELL;
                        state_next = S_DONE;
                    end
                end
                else if (ch_reg == tscw_pkg::NULL_BYTE)
                    state_next = S_DONE;
                else if (need_down)
                begin
                    if (can_step)
                    begin
                        row_next   = ROW_W'(row_p1);
                        col_next   = '0;
                        state_next = is_newline ? S_DONE : S_WRITE;
                    end
                    else
                    begin
                        scrolled_next = 1'b1;
                        sr_next       = ROW_W'(1);
                        sc_next       = '0;
                        // a single row in use has nothing to move
                        state_next    = (rows_eff == ROWS_W'(1)) ? S_BLANK : S_SCROLL;
                    end
                end
                else
                    state_next = S_WRITE;
            end
            S_RD_DATA:
            begin
                cell_next  = ram_rdata;
                state_next = S_DONE;
            end
            S_SCROLL:
            begin
                if (sc_last)
                begin
                    sc_next = '0;
                    sr_next = sr_reg + ROW_W'(1);
                    if (sr_reg == rows_m1)
                        state_next = S_FLUSH;
                end
                else
                    sc_next = sc_reg + COL_W'(1);
            end
            S_FLUSH:
            begin
                sc_next    = '0;
                state_next = S_BLANK;
            end
            S_BLANK:
            begin
                sc_next = sc_reg + COL_W'(1);
                if (sc_last)
                begin
                    row_next   = rows_m1;
                    col_next   = '0;
                    state_next = is_newline ? S_DONE : S_WRITE;
                end
            end
            S_WRITE:
            begin
                col_next   = col_reg + COLS_W'(1);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR_ALL;
            clr_cnt_reg    <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            sr_reg         <= '0;
            sc_reg         <= '0;
            pend_valid_reg <= 1'b0;
            scrolled_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cols_reg       <= tscw_pkg::COLS_RESET;
            rows_reg       <= tscw_pkg::ROWS_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            sr_reg         <= sr_next;
            sc_reg         <= sc_next;
            pend_valid_reg <= pend_valid_next;
            scrolled_reg   <= scrolled_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tscw_pkg::REG_COLS_IN_USE: cols_reg <= cfg_data[tscw_pkg::COLS_CFG_W-1:0];
                    tscw_pkg::REG_ROWS_IN_USE: rows_reg <= cfg_data[tscw_pkg::ROWS_CFG_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        cell_reg      <= cell_next;
        if (in_fire)
        begin
            func_reg <= func;
            ch_reg   <= char_in;
            rr_reg   <= read_row;
            rc_reg   <= read_col;
        end
        if (out_load)
        begin
            out_cell_reg <= cell_reg;
            out_row_reg  <= tscw_pkg::OUT_ROW_W'(row_reg);
            out_col_reg  <= tscw_pkg::OUT_COL_W'(col_reg);
            out_scr_reg  <= scrolled_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign cell_value     = out_cell_reg;
    assign cursor_row_out = out_row_reg;
    assign cursor_col_out = out_col_reg;
    assign scrolled       = out_scr_reg;

    `TSCW_ASSERT(a_no_write_idle, (state_reg == S_IDLE) |-> !ram_we, "store written while idle")
    `TSCW_ASSERT(a_fire_decide, in_fire |=> (state_reg == S_DECIDE), "accepted beat not decoded")
    `TSCW_ASSERT(a_scroll_src_row, (state_reg == S_SCROLL) |-> (sr_reg != '0), "scroll reads row zero")
    `TSCW_ASSERT_ALWAYS(a_col_bound, 32'(col_reg) <= MAX_COLS, "cursor column past store")

endmodule
